### rtl/rfgr_pkg.sv
package rfgr_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int OP_W    = 2;
    localparam int QUIET_W = 4;
    localparam int TDATA_W = 16;

    // operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [QUIET_W-1:0] QUIET_MAX   = 4'd15;
    localparam logic [QUIET_W-1:0] QUIET_RESET = 4'd2;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [QUIET_W-1:0] t_quiet;

endpackage

### rtl/rfgr_store.sv
module rfgr_store #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  rfgr_pkg::t_byte          i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output rfgr_pkg::t_byte          o_rd_data
);

    rfgr_pkg::t_byte r_mem [DEPTH];
    rfgr_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/rx_fifo_idle_gap_reader_core.sv
// Receive byte FIFO with idle-gap burst reads.
//
// Input channel (s_axis): tuser carries the operation (received byte, tick,
// read request); tdata carries the byte and the requested read length.
// Output channel (m_axis): one request per delivered byte, tdata carries the
// byte and the burst length, tlast marks the final byte of a burst.
// Config channel (cfg): writes the quiet tick limit; always ready.
//
// Each input request is accepted into the holding registers, then the
// sequencer applies it against the count, pointer and quiet-counter
// registers. A tick that fires a burst then streams the bytes from the
// ring store one per cycle while m_axis_tready stays high; the store
// read is registered and its address follows the next read pointer.
// s_axis_tready is low from acceptance until the last byte of a burst has
// been taken. When the receiver stalls, the current byte and tlast hold.
//
// Reset clears pointers, counts, the armed flag and the sequencer, and
// loads the quiet limit with two. Store contents are not cleared; only
// written entries are ever read.
module rx_fifo_idle_gap_reader_core #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input requests
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rfgr_pkg::TDATA_W-1:0]  s_axis_tdata,  // rx_byte[7:0], read_length[14:8]
    input  logic [rfgr_pkg::OP_W-1:0]     s_axis_tuser,  // operation[1:0]
    // delivered bytes
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rfgr_pkg::TDATA_W-1:0]  m_axis_tdata,  // data_byte[7:0], burst_length[14:8]
    output logic                          m_axis_tlast,
    // quiet limit register
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rfgr_pkg::QUIET_W-1:0]  i_cfg_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_LAST) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    logic [1:0]              r_state, n_state;
    logic [rfgr_pkg::OP_W-1:0] r_op;
    rfgr_pkg::t_byte         r_byte;
    rfgr_pkg::t_len          r_len;

    logic [PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic [CNT_W-1:0]        r_seen, n_seen;
    rfgr_pkg::t_quiet        r_quiet, n_quiet;
    logic                    r_armed, n_armed;
    rfgr_pkg::t_len          r_wanted, n_wanted;
    rfgr_pkg::t_quiet        r_limit;
    rfgr_pkg::t_len          r_left, n_left;
    rfgr_pkg::t_len          r_blen, n_blen;

    logic                    wr_en;
    rfgr_pkg::t_byte         rd_data;
    rfgr_pkg::t_len          seen_ext;
    rfgr_pkg::t_len          burst_n;
    logic                    in_fire;
    logic                    out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign seen_ext = rfgr_pkg::LEN_W'(r_seen);
    // fill equals seen when a burst fires, so one compare settles the length
    assign burst_n  = (r_wanted < seen_ext) ? r_wanted : seen_ext;

    always_comb begin
        n_state  = r_state;
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        n_seen   = r_seen;
        n_quiet  = r_quiet;
        n_armed  = r_armed;
        n_wanted = r_wanted;
        n_left   = r_left;
        n_blen   = r_blen;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_op == rfgr_pkg::OP_RX_BYTE) begin
                    // drop the byte when the store is full
                    if (r_fill != CNT_FULL) begin
                        wr_en    = 1'b1;
                        n_wr_ptr = ptr_inc(r_wr_ptr);
                        n_fill   = r_fill + 1'b1;
                    end
                end else if (r_op == rfgr_pkg::OP_READ) begin
                    n_armed  = 1'b1;
                    n_wanted = r_len;
                    n_seen   = '0;
                    n_quiet  = '0;
                end else if (r_op == rfgr_pkg::OP_TICK && r_armed) begin
                    if (r_fill != r_seen) begin
                        n_seen  = r_fill;
                        n_quiet = '0;
                    end else if (r_quiet <= r_limit) begin
                        if (r_quiet != rfgr_pkg::QUIET_MAX) begin
                            n_quiet = r_quiet + 1'b1;
                        end
                    end else begin
                        n_quiet = '0;
                        if (r_seen != '0) begin
                            n_armed = 1'b0;
                            if (burst_n != '0) begin
                                n_left  = burst_n;
                                n_blen  = burst_n;
                                n_state = S_SEND;
                            end
                        end
                    end
                end
            end
            S_SEND: begin
                if (out_fire) begin
                    n_rd_ptr = ptr_inc(r_rd_ptr);
                    n_fill   = r_fill - 1'b1;
                    n_left   = r_left - 1'b1;
                    if (r_left == rfgr_pkg::LEN_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
            r_seen   <= '0;
            r_quiet  <= '0;
            r_armed  <= 1'b0;
            r_wanted <= '0;
            r_limit  <= rfgr_pkg::QUIET_RESET;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_fill   <= n_fill;
            r_seen   <= n_seen;
            r_quiet  <= n_quiet;
            r_armed  <= n_armed;
            r_wanted <= n_wanted;
            r_left   <= n_left;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // hold the accepted request and the burst length
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= s_axis_tuser;
            r_byte <= s_axis_tdata[rfgr_pkg::BYTE_W-1:0];
            r_len  <= s_axis_tdata[rfgr_pkg::BYTE_W +: rfgr_pkg::LEN_W];
        end
        r_blen <= n_blen;
    end

    // read address follows the next pointer so each accepted byte is
    // replaced by the following one on the next cycle
    rfgr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_byte),
        .i_rd_addr (n_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_SEND);
    assign m_axis_tlast  = (r_left == rfgr_pkg::LEN_W'(1));
    assign m_axis_tdata  = {1'b0, r_blen, rd_data};
    assign o_cfg_ready   = 1'b1;

endmodule

### bench/rx_fifo_idle_gap_reader_core_tb.sv
module rx_fifo_idle_gap_reader_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH  = 64;
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int SETTLE      = 8;     // covers the accept and sequencer steps of the request pipeline

    // operation code the block must ignore
    localparam logic [rfgr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [rfgr_pkg::OP_W-1:0] op;
        rfgr_pkg::t_byte           rx;
        rfgr_pkg::t_len            len;
    } t_rx_request;

    typedef struct {
        rfgr_pkg::t_byte data;
        logic            last;
        rfgr_pkg::t_len  blen;
    } t_delivery;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rfgr_pkg::TDATA_W-1:0]    s_axis_tdata  = '0;  // rx_byte[7:0], read_length[14:8]
    logic [rfgr_pkg::OP_W-1:0]       s_axis_tuser  = '0;  // operation[1:0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rfgr_pkg::TDATA_W-1:0]    m_axis_tdata;        // data_byte[7:0], burst_length[14:8]
    logic                            m_axis_tlast;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [rfgr_pkg::QUIET_W-1:0]    i_cfg_data    = '0;

    rx_fifo_idle_gap_reader_core #(
        .DEPTH(FIFO_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow FIFO and idle-gap reader, stepped once per accepted request
    // ------------------------------------------------------------------
    rfgr_pkg::t_byte   fifo_mem [FIFO_DEPTH];
    logic [5:0]        fifo_rd_ptr  = '0;
    logic [5:0]        fifo_wr_ptr  = '0;
    logic [6:0]        fifo_fill    = '0;
    logic [6:0]        snap_fill    = '0;
    rfgr_pkg::t_quiet  quiet_ticks  = '0;
    logic              reader_armed = 1'b0;
    rfgr_pkg::t_len    want_len     = '0;
    rfgr_pkg::t_quiet  quiet_limit  = rfgr_pkg::QUIET_RESET;

    t_delivery    bytes_due [$];        // bytes the block still owes, oldest first
    t_rx_request  requests_pending [$]; // requests not yet handed to the driver

    int in_idle_pct  = 28;
    int out_idle_pct = 60;
    int mismatches   = 0;
    int queued       = 0;
    int idle_cycles  = 0;
    logic in_took    = 1'b0;
    logic cfg_took   = 1'b0;

    function automatic void apply_request(t_rx_request r);
        int n;
        unique case (r.op)
            rfgr_pkg::OP_RX_BYTE: begin
                // drop the byte when the ring is full
                if (fifo_fill < FIFO_DEPTH) begin
                    fifo_mem[fifo_wr_ptr] = r.rx;
                    fifo_wr_ptr++;
                    fifo_fill++;
                end
            end
            rfgr_pkg::OP_READ: begin
                // (re)arm: forget any earlier snapshot and quiet run
                reader_armed = 1'b1;
                want_len     = r.len;
                snap_fill    = '0;
                quiet_ticks  = '0;
            end
            rfgr_pkg::OP_TICK: begin
                if (reader_armed) begin
                    if (fifo_fill != snap_fill) begin
                        snap_fill   = fifo_fill;
                        quiet_ticks = '0;
                    end else if (quiet_ticks <= quiet_limit) begin
                        if (quiet_ticks < rfgr_pkg::QUIET_MAX)
                            quiet_ticks++;
                    end else begin
                        quiet_ticks = '0;
                        // an empty snapshot keeps the reader waiting
                        if (snap_fill != 0) begin
                            n = (want_len < snap_fill) ? want_len : snap_fill;
                            for (int k = 0; k < n; k++) begin
                                bytes_due.push_back('{fifo_mem[fifo_rd_ptr], k == n - 1,
                                                      rfgr_pkg::t_len'(n)});
                                fifo_rd_ptr++;
                            end
                            fifo_fill    = fifo_fill - 7'(n);
                            reader_armed = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next request at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_rx_request r;
        if (i_rst_n && (!s_axis_tvalid || in_took)) begin
            if (requests_pending.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                r = requests_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, r.len, r.rx};
                s_axis_tuser  <= r.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check delivered bytes, then step the shadow model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_delivery   d;
        t_rx_request r;
        logic        fire_in;
        logic        fire_out;
        logic        fire_cfg;
        fire_in  = i_rst_n && s_axis_tvalid && s_axis_tready;
        fire_out = i_rst_n && m_axis_tvalid && m_axis_tready;
        fire_cfg = i_rst_n && i_cfg_valid && o_cfg_ready;

        if (fire_out) begin
            if (bytes_due.size() == 0) begin
                report_mismatch("unexpected byte", m_axis_tdata, 0);
            end else begin
                d = bytes_due.pop_front();
                if (m_axis_tdata[7:0] !== d.data)
                    report_mismatch("data_byte", m_axis_tdata[7:0], d.data);
                if (m_axis_tlast !== d.last)
                    report_mismatch("last", m_axis_tlast, d.last);
                if (m_axis_tdata[14:8] !== d.blen)
                    report_mismatch("burst_length", m_axis_tdata[14:8], d.blen);
            end
        end

        if (fire_in) begin
            r.op  = s_axis_tuser;
            r.rx  = s_axis_tdata[7:0];
            r.len = s_axis_tdata[14:8];
            apply_request(r);
        end

        if (fire_cfg)
            quiet_limit = i_cfg_data;

        in_took     <= fire_in;
        cfg_took    <= fire_cfg;
        idle_cycles <= (fire_in || fire_out || fire_cfg) ? 0 : idle_cycles + 1;
    end

    // Watchdog: end the run when the handshakes stop
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(logic [rfgr_pkg::OP_W-1:0] op, rfgr_pkg::t_byte rx,
                             rfgr_pkg::t_len len);
        requests_pending.push_back('{op, rx, len});
        queued++;
    endtask

    // mostly in range, sometimes zero or beyond the ring depth
    function automatic rfgr_pkg::t_len pick_read_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return rfgr_pkg::t_len'($urandom_range(65, 127));
        return rfgr_pkg::t_len'($urandom_range(1, 64));
    endfunction

    task automatic queue_traffic(int target);
        int start;
        int kind;
        int nbytes;
        int nticks;
        start = queued;
        while (queued - start < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // well-formed: fill, request, then enough quiet ticks to fire
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                     : $urandom_range(0, 12);
                repeat (nbytes)
                    push_item(rfgr_pkg::OP_RX_BYTE, rfgr_pkg::t_byte'($urandom),
                              rfgr_pkg::t_len'($urandom));
                push_item(rfgr_pkg::OP_READ, rfgr_pkg::t_byte'($urandom),
                          pick_read_length());
                nticks = quiet_limit + 3 + $urandom_range(0, 3);
                repeat (nticks) begin
                    // a late byte restarts the quiet run
                    if ($urandom_range(0, 7) == 0)
                        push_item(rfgr_pkg::OP_RX_BYTE, rfgr_pkg::t_byte'($urandom),
                                  rfgr_pkg::t_len'($urandom));
                    push_item(rfgr_pkg::OP_TICK, rfgr_pkg::t_byte'($urandom),
                              rfgr_pkg::t_len'($urandom));
                end
            end else if (kind < 9) begin
                // noise, the unused code included
                repeat ($urandom_range(1, 6))
                    push_item(rfgr_pkg::OP_W'($urandom_range(0, 3)),
                              rfgr_pkg::t_byte'($urandom), rfgr_pkg::t_len'($urandom));
            end else begin
                // broken: request cut short by bytes before it can fire
                push_item(rfgr_pkg::OP_READ, rfgr_pkg::t_byte'($urandom),
                          pick_read_length());
                repeat ($urandom_range(0, quiet_limit + 1))
                    push_item(rfgr_pkg::OP_TICK, rfgr_pkg::t_byte'($urandom),
                              rfgr_pkg::t_len'($urandom));
                repeat ($urandom_range(0, 3))
                    push_item(rfgr_pkg::OP_RX_BYTE, rfgr_pkg::t_byte'($urandom),
                              rfgr_pkg::t_len'($urandom));
            end
        end
    endtask

    // hold until every request is taken and every byte delivered
    task automatic wait_drained();
        while (requests_pending.size() != 0 || s_axis_tvalid || bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_quiet_limit(rfgr_pkg::t_quiet value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_took);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(rfgr_pkg::t_quiet lim, int in_pct, int out_pct, int n);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        write_quiet_limit(lim);
        queue_traffic(n);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at the reset quiet limit of two
        push_item(rfgr_pkg::OP_TICK,    8'hFF, 7'h7F);   // tick with reader idle
        push_item(OP_UNUSED,            8'hFF, 7'h7F);   // unused code
        push_item(rfgr_pkg::OP_RX_BYTE, 8'h00, 7'h00);
        push_item(rfgr_pkg::OP_RX_BYTE, 8'hFF, 7'h7F);
        push_item(rfgr_pkg::OP_RX_BYTE, 8'hA5, 7'h00);
        push_item(rfgr_pkg::OP_READ,    8'h00, 7'd64);
        repeat (5) push_item(rfgr_pkg::OP_TICK, 8'h00, 7'h00);   // burst of three
        push_item(rfgr_pkg::OP_RX_BYTE, 8'h5A, 7'h00);
        push_item(rfgr_pkg::OP_READ,    8'h00, 7'd0);            // zero length: fires empty
        repeat (5) push_item(rfgr_pkg::OP_TICK, 8'h00, 7'h00);
        push_item(rfgr_pkg::OP_READ,    8'h00, 7'd1);
        push_item(rfgr_pkg::OP_READ,    8'h00, 7'd127);          // re-arm while armed
        repeat (5) push_item(rfgr_pkg::OP_TICK, 8'h00, 7'h00);
        wait_drained();

        // random phases: receiver slow first, then sender slow, then no idling
        run_phase(4'd0,  28, 60, 65);
        run_phase(4'd15, 28, 60, 35);   // never fires at this limit
        run_phase(4'd3,  60, 28, 65);
        run_phase(rfgr_pkg::t_quiet'($urandom_range(4, 13)), 60, 28, 65);
        run_phase(4'd1,  0,  0,  65);
        run_phase(4'd14, 0,  0,  65);

        if (bytes_due.size() != 0)
            report_mismatch("bytes never delivered", 0, bytes_due.size());
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rfgr_pkg.sv
rtl/rfgr_store.sv
rtl/rx_fifo_idle_gap_reader_core.sv
bench/rx_fifo_idle_gap_reader_core_tb.sv
